// ----- src/bdi_pkg.sv -----
// Types, constants, fixed-point helpers and microcode ROM of the backward difference interpolator.
`default_nettype none
package bdi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_W     = 33 + FRAC_BITS;
    localparam int DCNT_W    = $clog2(DIV_W + 1);
    localparam int PC_W      = 5;

    localparam logic signed [31:0] ONE    = 32'sd1 <<< FRAC_BITS;
    localparam logic [2:0]          NPTS  = 3'd4;
    localparam logic                FUNC_LOAD   = 1'b0;
    localparam logic [31:0]         RECIP_THREE = 32'hAAAA_AAAB;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SPACING = 2'd1,
        ST_FEW     = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    typedef struct packed {
        logic               func;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } t_item;

    typedef struct packed {
        logic signed [31:0] value;
        t_status            status;
    } t_result;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] v;
    } t_satv;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_DIFF, OP_SETP, OP_SETQ, OP_MUL, OP_QMUL, OP_HALF,
        OP_DIV6, OP_RECIP, OP_ACC1, OP_ACC2, OP_ACC3, OP_EMIT_OK, OP_EMIT_FEW,
        OP_EMIT_HZ
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT, C_ALWAYS, C_IDLE, C_LOAD, C_FEW, C_HZERO, C_DIVBUSY
    } t_cond;

    typedef enum logic [2:0] {
        SRC_P, SRC_Q1, SRC_Q2, SRC_B, SRC_C, SRC_D1, SRC_D2, SRC_D3
    } t_src;

    typedef enum logic [1:0] {
        DST_A, DST_B, DST_C
    } t_dst;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
        t_src            src_a;
        t_src            src_b;
        t_dst            dst;
    } t_ucode;

    typedef struct packed {
        logic is_load;
        logic few;
        logic hzero;
        logic div_busy;
    } t_flags;

    localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
    localparam logic [PC_W-1:0] PC_DISPATCH = 5'd1;
    localparam logic [PC_W-1:0] PC_CHECK    = 5'd2;
    localparam logic [PC_W-1:0] PC_DIFF     = 5'd3;
    localparam logic [PC_W-1:0] PC_WAITP    = 5'd4;
    localparam logic [PC_W-1:0] PC_SETP     = 5'd5;
    localparam logic [PC_W-1:0] PC_SETQ     = 5'd6;
    localparam logic [PC_W-1:0] PC_MUL_A    = 5'd7;
    localparam logic [PC_W-1:0] PC_ST_A     = 5'd8;
    localparam logic [PC_W-1:0] PC_MUL_B    = 5'd9;
    localparam logic [PC_W-1:0] PC_ST_B     = 5'd10;
    localparam logic [PC_W-1:0] PC_MUL_C    = 5'd11;
    localparam logic [PC_W-1:0] PC_ST_C     = 5'd12;
    localparam logic [PC_W-1:0] PC_MUL_T2   = 5'd13;
    localparam logic [PC_W-1:0] PC_ST_T2    = 5'd14;
    localparam logic [PC_W-1:0] PC_MUL_T3   = 5'd15;
    localparam logic [PC_W-1:0] PC_DIV6     = 5'd16;
    localparam logic [PC_W-1:0] PC_ACC1     = 5'd17;
    localparam logic [PC_W-1:0] PC_ACC2     = 5'd18;
    localparam logic [PC_W-1:0] PC_RECIP    = 5'd19;
    localparam logic [PC_W-1:0] PC_ACC3     = 5'd20;
    localparam logic [PC_W-1:0] PC_EMIT     = 5'd21;
    localparam logic [PC_W-1:0] PC_LOAD     = 5'd22;
    localparam logic [PC_W-1:0] PC_FEW      = 5'd23;
    localparam logic [PC_W-1:0] PC_HZ       = 5'd24;
    localparam logic [PC_W-1:0] PC_LAST     = PC_HZ;

    function automatic t_satv f_sat32(input logic signed [63:0] v);
        t_satv r;
        r.sat = 1'b0;
        r.v   = v[31:0];
        if (v > 64'sd2147483647) begin
            r.sat = 1'b1;
            r.v   = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r.sat = 1'b1;
            r.v   = 32'sh8000_0000;
        end
        return r;
    endfunction

    function automatic t_satv f_sat_mag(input logic [DIV_W-1:0] m, input logic neg);
        t_satv r;
        r.sat = 1'b0;
        r.v   = m[31:0];
        if (neg) begin
            if (m > DIV_W'(33'h0_8000_0000)) begin
                r.sat = 1'b1;
                r.v   = 32'sh8000_0000;
            end else begin
                r.v   = 32'(32'd0 - m[31:0]);
            end
        end else if (m > DIV_W'(33'h0_7FFF_FFFF)) begin
            r.sat = 1'b1;
            r.v   = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // divide by 2^(FRAC_BITS + half), rounding toward zero
    function automatic logic signed [63:0] f_qshift(input logic signed [63:0] v,
                                                   input logic half);
        logic signed [63:0] bias;
        bias = 64'sd0;
        if (v[63]) begin
            bias = half ? ((64'sd1 <<< (FRAC_BITS + 1)) - 64'sd1)
                        : ((64'sd1 <<< FRAC_BITS) - 64'sd1);
        end
        return half ? ((v + bias) >>> (FRAC_BITS + 1)) : ((v + bias) >>> FRAC_BITS);
    endfunction

    function automatic t_ucode f_ucode(input logic [PC_W-1:0] pc);
        t_ucode uc;
        uc = '{op: OP_NOP, cond: C_NEXT, target: PC_IDLE,
               src_a: SRC_P, src_b: SRC_P, dst: DST_A};
        case (pc)
            PC_IDLE: begin
                uc.cond = C_IDLE;
            end
            PC_DISPATCH: begin
                uc.cond   = C_LOAD;
                uc.target = PC_LOAD;
            end
            PC_CHECK: begin
                uc.cond   = C_FEW;
                uc.target = PC_FEW;
            end
            PC_DIFF: begin
                uc.op     = OP_DIFF;
                uc.cond   = C_HZERO;
                uc.target = PC_HZ;
            end
            PC_WAITP: begin
                uc.cond   = C_DIVBUSY;
                uc.target = PC_WAITP;
            end
            PC_SETP:  uc.op = OP_SETP;
            PC_SETQ:  uc.op = OP_SETQ;
            PC_MUL_A: begin
                uc.op    = OP_MUL;
                uc.src_a = SRC_P;
                uc.src_b = SRC_D1;
            end
            PC_ST_A: begin
                uc.op  = OP_QMUL;
                uc.dst = DST_A;
            end
            PC_MUL_B: begin
                uc.op    = OP_MUL;
                uc.src_a = SRC_P;
                uc.src_b = SRC_Q1;
            end
            PC_ST_B: begin
                uc.op  = OP_QMUL;
                uc.dst = DST_B;
            end
            PC_MUL_C: begin
                uc.op    = OP_MUL;
                uc.src_a = SRC_B;
                uc.src_b = SRC_Q2;
            end
            PC_ST_C: begin
                uc.op  = OP_QMUL;
                uc.dst = DST_C;
            end
            PC_MUL_T2: begin
                uc.op    = OP_MUL;
                uc.src_a = SRC_B;
                uc.src_b = SRC_D2;
            end
            PC_ST_T2: uc.op = OP_HALF;
            PC_MUL_T3: begin
                uc.op    = OP_MUL;
                uc.src_a = SRC_C;
                uc.src_b = SRC_D3;
            end
            PC_DIV6:  uc.op = OP_DIV6;
            PC_ACC1:  uc.op = OP_ACC1;
            PC_ACC2:  uc.op = OP_ACC2;
            PC_RECIP: uc.op = OP_RECIP;
            PC_ACC3:  uc.op = OP_ACC3;
            PC_EMIT: begin
                uc.op   = OP_EMIT_OK;
                uc.cond = C_ALWAYS;
            end
            PC_LOAD: begin
                uc.op   = OP_LOAD;
                uc.cond = C_ALWAYS;
            end
            PC_FEW: begin
                uc.op   = OP_EMIT_FEW;
                uc.cond = C_ALWAYS;
            end
            PC_HZ: begin
                uc.op   = OP_EMIT_HZ;
                uc.cond = C_ALWAYS;
            end
            default: begin
                uc.cond = C_ALWAYS;
            end
        endcase
        return uc;
    endfunction

endpackage
`default_nettype wire

// ----- src/bdi_div.sv -----
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
`default_nettype none
module bdi_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bdi_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [32:0]                i_divisor,
    output logic                            o_busy,
    output logic [bdi_pkg::DIV_W-1:0]       o_quotient
);
    import bdi_pkg::*;

    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [32:0]       r_rem, n_rem;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [32:0]       r_dsr, n_dsr;
    logic [33:0]       w_shift;
    logic [34:0]       w_trial;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_dsr};

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        n_dsr = r_dsr;
        if (i_start) begin
            n_cnt = DCNT_W'(DIV_W);
            n_rem = '0;
            n_quo = i_dividend;
            n_dsr = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (!w_trial[34]) begin
                n_rem = w_trial[32:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[32:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DCNT_W'(DIV_W))
        else $error("divider step count out of range");
`endif

endmodule
`default_nettype wire

// ----- src/bdi_dp.sv -----
// Datapath: sample store, difference terms, multiplier, accumulator and result register.
`default_nettype none
module bdi_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire bdi_pkg::t_item   i_item,
    input  wire bdi_pkg::t_ucode  i_uc,
    output bdi_pkg::t_flags       o_flags,
    output bdi_pkg::t_result      o_result,
    output logic                  o_done
);
    import bdi_pkg::*;

    t_item              r_item, n_item;
    logic signed [31:0] r_xs [4];
    logic signed [31:0] r_ys [4];
    logic signed [31:0] n_xs [4];
    logic signed [31:0] n_ys [4];
    logic [2:0]         r_cnt, n_cnt;
    logic signed [31:0] r_d1, r_d2, r_d3, r_p, r_q1, r_q2, r_a, r_b, r_c, r_t2, r_acc;
    logic signed [31:0] n_d1, n_d2, n_d3, n_p, n_q1, n_q2, n_a, n_b, n_c, n_t2, n_acc;
    logic signed [63:0] r_prod, n_prod;
    logic               r_sat, n_sat;
    logic               r_neg, n_neg;
    logic [32:0]        r_u, n_u;
    logic [31:0]        r_q6, n_q6;
    t_result            r_res, n_res;
    logic               r_done, n_done;

    logic               w_div_start;
    logic [DIV_W-1:0]   w_dividend;
    logic [32:0]        w_divisor;
    logic               w_div_busy;
    logic [DIV_W-1:0]   w_quo;

    logic signed [35:0] w_e0, w_e1, w_e2, w_e3;
    logic signed [35:0] w_d1w, w_d2w, w_d3w;
    logic signed [32:0] w_h, w_dx;
    logic [32:0]        w_hmag, w_dxmag;
    logic signed [63:0] w_qm;
    logic [63:0]        w_qmag;
    logic [64:0]        w_recip;
    logic signed [31:0] w_opa, w_opb;
    t_satv              w_s1, w_s2, w_s3;

    bdi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    assign w_e0  = 36'(r_ys[0]);
    assign w_e1  = 36'(r_ys[1]);
    assign w_e2  = 36'(r_ys[2]);
    assign w_e3  = 36'(r_ys[3]);
    assign w_d1w = w_e3 - w_e2;
    assign w_d2w = w_e3 - (w_e2 <<< 1) + w_e1;
    assign w_d3w = w_e3 - ((w_e2 <<< 1) + w_e2) + ((w_e1 <<< 1) + w_e1) - w_e0;

    assign w_h     = 33'(r_xs[1]) - 33'(r_xs[0]);
    assign w_dx    = 33'(r_item.x_value) - 33'(r_xs[3]);
    assign w_hmag  = w_h[32] ? 33'(-w_h) : w_h;
    assign w_dxmag = w_dx[32] ? 33'(-w_dx) : w_dx;

    assign w_qm   = f_qshift(r_prod, 1'b0);
    assign w_qmag = w_qm[63] ? 64'(-w_qm) : 64'(w_qm);

    assign w_div_start = i_uc.op == OP_DIFF;
    assign w_dividend  = {w_dxmag, {FRAC_BITS{1'b0}}};
    assign w_divisor   = w_hmag;
    assign w_recip     = 65'(r_u) * 65'(RECIP_THREE);

    always_comb begin
        case (i_uc.src_a)
            SRC_P:   w_opa = r_p;
            SRC_Q1:  w_opa = r_q1;
            SRC_Q2:  w_opa = r_q2;
            SRC_B:   w_opa = r_b;
            SRC_C:   w_opa = r_c;
            SRC_D1:  w_opa = r_d1;
            SRC_D2:  w_opa = r_d2;
            SRC_D3:  w_opa = r_d3;
            default: w_opa = r_p;
        endcase
        case (i_uc.src_b)
            SRC_P:   w_opb = r_p;
            SRC_Q1:  w_opb = r_q1;
            SRC_Q2:  w_opb = r_q2;
            SRC_B:   w_opb = r_b;
            SRC_C:   w_opb = r_c;
            SRC_D1:  w_opb = r_d1;
            SRC_D2:  w_opb = r_d2;
            SRC_D3:  w_opb = r_d3;
            default: w_opb = r_p;
        endcase
    end

    always_comb begin
        n_item = r_item;
        n_xs   = r_xs;
        n_ys   = r_ys;
        n_cnt  = r_cnt;
        n_d1   = r_d1;
        n_d2   = r_d2;
        n_d3   = r_d3;
        n_p    = r_p;
        n_q1   = r_q1;
        n_q2   = r_q2;
        n_a    = r_a;
        n_b    = r_b;
        n_c    = r_c;
        n_t2   = r_t2;
        n_acc  = r_acc;
        n_prod = r_prod;
        n_sat  = r_sat;
        n_neg  = r_neg;
        n_u    = r_u;
        n_q6   = r_q6;
        n_res  = r_res;
        n_done = 1'b0;
        w_s1   = f_sat32(64'(w_d1w));
        w_s2   = f_sat32(64'(w_d2w));
        w_s3   = f_sat32(64'(w_d3w));

        if (i_accept) begin
            n_item = i_item;
            n_sat  = 1'b0;
        end

        case (i_uc.op)
            OP_LOAD: begin
                if (r_cnt != NPTS) begin
                    n_xs[r_cnt[1:0]] = r_item.x_value;
                    n_ys[r_cnt[1:0]] = r_item.y_value;
                    n_cnt            = r_cnt + 3'd1;
                end else begin
                    n_xs = '{r_xs[1], r_xs[2], r_xs[3], r_item.x_value};
                    n_ys = '{r_ys[1], r_ys[2], r_ys[3], r_item.y_value};
                end
            end
            OP_DIFF: begin
                n_d1  = w_s1.v;
                n_d2  = w_s2.v;
                n_d3  = w_s3.v;
                n_sat = r_sat | w_s1.sat | w_s2.sat | w_s3.sat;
                n_neg = w_dx[32] ^ w_h[32];
            end
            OP_SETP: begin
                w_s1  = f_sat_mag(w_quo, r_neg);
                n_p   = w_s1.v;
                n_sat = r_sat | w_s1.sat;
            end
            OP_SETQ: begin
                w_s1  = f_sat32(64'(r_p) + 64'(ONE));
                w_s2  = f_sat32(64'(r_p) + 64'(ONE) + 64'(ONE));
                n_q1  = w_s1.v;
                n_q2  = w_s2.v;
                n_sat = r_sat | w_s1.sat | w_s2.sat;
            end
            OP_MUL: begin
                n_prod = w_opa * w_opb;
            end
            OP_QMUL: begin
                w_s1  = f_sat32(w_qm);
                n_sat = r_sat | w_s1.sat;
                case (i_uc.dst)
                    DST_A:   n_a = w_s1.v;
                    DST_B:   n_b = w_s1.v;
                    DST_C:   n_c = w_s1.v;
                    default: n_a = w_s1.v;
                endcase
            end
            OP_HALF: begin
                w_s1  = f_sat32(f_qshift(r_prod, 1'b1));
                n_t2  = w_s1.v;
                n_sat = r_sat | w_s1.sat;
            end
            OP_DIV6: begin
                n_neg = w_qm[63];
                // hold the halved magnitude; clamp what saturates after the divide anyway
                n_u   = (|w_qmag[63:34]) ? '1 : w_qmag[33:1];
            end
            OP_RECIP: begin
                n_q6 = w_recip[64:33];
            end
            OP_ACC1: begin
                w_s1  = f_sat32(64'(r_ys[3]) + 64'(r_a));
                n_acc = w_s1.v;
                n_sat = r_sat | w_s1.sat;
            end
            OP_ACC2: begin
                w_s1  = f_sat32(64'(r_acc) + 64'(r_t2));
                n_acc = w_s1.v;
                n_sat = r_sat | w_s1.sat;
            end
            OP_ACC3: begin
                w_s1  = f_sat_mag(DIV_W'(r_q6), r_neg);
                w_s2  = f_sat32(64'(r_acc) + 64'(w_s1.v));
                n_acc = w_s2.v;
                n_sat = r_sat | w_s1.sat | w_s2.sat;
            end
            OP_EMIT_OK: begin
                n_res.value  = r_acc;
                n_res.status = r_sat ? ST_SAT : ST_OK;
                n_done       = 1'b1;
            end
            OP_EMIT_FEW: begin
                n_res.value  = '0;
                n_res.status = ST_FEW;
                n_done       = 1'b1;
            end
            OP_EMIT_HZ: begin
                n_res.value  = '0;
                n_res.status = ST_SPACING;
                n_done       = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_item <= n_item;
        r_xs   <= n_xs;
        r_ys   <= n_ys;
        r_d1   <= n_d1;
        r_d2   <= n_d2;
        r_d3   <= n_d3;
        r_p    <= n_p;
        r_q1   <= n_q1;
        r_q2   <= n_q2;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_t2   <= n_t2;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_sat  <= n_sat;
        r_neg  <= n_neg;
        r_u    <= n_u;
        r_q6   <= n_q6;
        r_res  <= n_res;
    end

    assign o_flags.is_load  = r_item.func == FUNC_LOAD;
    assign o_flags.few      = r_cnt != NPTS;
    assign o_flags.hzero    = r_xs[1] == r_xs[0];
    assign o_flags.div_busy = w_div_busy;
    assign o_result         = r_res;
    assign o_done           = r_done;

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NPTS)
        else $error("point count beyond four");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("results on consecutive cycles");
`endif

endmodule
`default_nettype wire

// ----- src/bdi_seq.sv -----
// Microcode sequencer: step counter, ROM lookup and jump condition select.
`default_nettype none
module bdi_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire bdi_pkg::t_flags  i_flags,
    output bdi_pkg::t_ucode       o_uc,
    output logic                  o_busy
);
    import bdi_pkg::*;

    logic [PC_W-1:0] r_pc, n_pc;
    t_ucode          w_uc;
    logic            w_take;

    assign w_uc = f_ucode(r_pc);

    always_comb begin
        case (w_uc.cond)
            C_NEXT:    w_take = 1'b0;
            C_ALWAYS:  w_take = 1'b1;
            C_IDLE:    w_take = !i_accept;
            C_LOAD:    w_take = i_flags.is_load;
            C_FEW:     w_take = i_flags.few;
            C_HZERO:   w_take = i_flags.hzero;
            C_DIVBUSY: w_take = i_flags.div_busy;
            default:   w_take = 1'b1;
        endcase
        n_pc = w_take ? w_uc.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uc   = w_uc;
    assign o_busy = r_pc != PC_IDLE;

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PC_LAST)
        else $error("step counter outside the program");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_pc == PC_DISPATCH)
        else $error("accepted item not dispatched");
`endif

endmodule
`default_nettype wire

// ----- src/backward_difference_interpolator.sv -----
// Top level of the backward difference interpolator.
//
//  channel  | ports                           | handshake
//  ---------+---------------------------------+--------------------------------
//  input    | start, busy, i_item             | taken when start && !busy
//  result   | o_done, o_result                | one-cycle strobe, no back-pressure
//
// A load holds busy high through the dispatch and load steps after acceptance.
// A query with under four points or zero spacing raises the strobe from the FEW or HZ step.
// A full query waits on the bit-serial divider for p, then runs the multiply and accumulate steps;
// the divide by six is a halving and a multiply by the reciprocal of three.
// Reset clears the step counter, divider count, point count and result strobe.
// The result strobe rises in the cycle after the last step; the next item may be taken then.
`default_nettype none
module backward_difference_interpolator (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bdi_pkg::t_item    i_item,
    output logic                   o_done,
    output bdi_pkg::t_result       o_result
);
    import bdi_pkg::*;

    logic   w_accept;
    t_ucode w_uc;
    t_flags w_flags;

    assign w_accept = start && !busy;

    bdi_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_flags  (w_flags),
        .o_uc     (w_uc),
        .o_busy   (busy)
    );

    bdi_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .i_uc     (w_uc),
        .o_flags  (w_flags),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule
`default_nettype wire

// ----- tb/backward_difference_interpolator_tb.sv -----
// Self-checking testbench: directed and random loads and queries against a fixed-point predictor.
`timescale 1ns / 100ps
module backward_difference_interpolator_tb;
    import bdi_pkg::*;

    localparam logic     FUNC_QUERY    = 1'b1;
    localparam int       DIR_N         = 25;
    localparam int       RAND_ITEMS    = 625;
    localparam int       QUERY_CYCLES  = (33 + FRAC_BITS) + 22;
    localparam int       TAIL_CYCLES   = QUERY_CYCLES + 40;
    localparam int       QUIET_LIMIT   = 3000;
    localparam longint   MAX32         = 64'sd2147483647;
    localparam longint   MIN32         = -64'sd2147483648;
    localparam longint   ONE_L         = 64'sd1 <<< FRAC_BITS;

    typedef struct packed {
        t_item   item;
        logic    typed;
        t_result res;
    } t_dir_row;

    localparam t_dir_row DIRECTED [DIR_N] = '{
        '{'{FUNC_QUERY, 32'h7FFF_FFFF, 32'h0000_0000}, 1'b1, '{32'h0, ST_FEW}},
        '{'{FUNC_LOAD,  32'h0001_0000, 32'h8000_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_LOAD,  32'h0001_0000, 32'h7FFF_FFFF}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_LOAD,  32'h0002_0000, 32'h0000_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_QUERY, 32'h8000_0000, 32'hFFFF_FFFF}, 1'b1, '{32'h0, ST_FEW}},
        '{'{FUNC_LOAD,  32'h0003_0000, 32'h0001_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_QUERY, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{32'h0, ST_SPACING}},
        '{'{FUNC_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1, '{32'h0, ST_SPACING}},
        '{'{FUNC_LOAD,  32'h0004_0000, 32'h0002_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_QUERY, 32'h0004_0000, 32'h0000_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_LOAD,  32'h0000_0000, 32'h0000_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_LOAD,  32'h0001_0000, 32'h0001_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_LOAD,  32'h0002_0000, 32'h0008_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_LOAD,  32'h0003_0000, 32'h001B_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_QUERY, 32'h0003_0000, 32'h0000_0000}, 1'b1, '{32'h001B_0000, ST_OK}},
        '{'{FUNC_QUERY, 32'h0004_0000, 32'h0000_0000}, 1'b1, '{32'h0040_0000, ST_OK}},
        '{'{FUNC_QUERY, 32'h8000_0000, 32'h0000_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_QUERY, 32'h7FFF_FFFF, 32'h0000_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_QUERY, 32'h0001_8000, 32'h0000_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_LOAD,  32'hFFFF_0000, 32'hFFFF_FFFF}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_QUERY, 32'h0000_0000, 32'h0000_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_LOAD,  32'h8000_0000, 32'h8000_0000}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_LOAD,  32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '{32'h0, ST_OK}},
        '{'{FUNC_QUERY, 32'h8000_0000, 32'h1234_5678}, 1'b0, '{32'h0, ST_OK}}
    };

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   cmd_item = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    logic signed [31:0] pt_x [4];
    logic signed [31:0] pt_y [4];
    int                 pt_count = 0;
    bit                 sat_seen;
    t_result            queued_answers [$];
    int                 items_sent   = 0;
    int                 burst_left   = 0;
    int                 mismatches   = 0;
    int                 quiet_cycles = 0;

    backward_difference_interpolator DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (cmd_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint clip32(longint v);
        if (v > MAX32) begin
            sat_seen = 1'b1;
            return MAX32;
        end
        if (v < MIN32) begin
            sat_seen = 1'b1;
            return MIN32;
        end
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return (a * b) / ONE_L;
    endfunction

    function automatic t_result newton_backward_eval(logic signed [31:0] xq);
        t_result r;
        longint  h, y0, y1, y2, y3, d1, d2, d3, p, q1, q2, a, b, c, t2, t3, acc;
        r.value  = '0;
        r.status = ST_FEW;
        if (pt_count < int'(NPTS)) return r;
        r.status = ST_SPACING;
        h = longint'(pt_x[1]) - longint'(pt_x[0]);
        if (h == 0) return r;
        y0 = longint'(pt_y[0]);
        y1 = longint'(pt_y[1]);
        y2 = longint'(pt_y[2]);
        y3 = longint'(pt_y[3]);
        sat_seen = 1'b0;
        d1  = clip32(y3 - y2);
        d2  = clip32(y3 - 2 * y2 + y1);
        d3  = clip32(y3 - 3 * y2 + 3 * y1 - y0);
        p   = clip32(((longint'(xq) - longint'(pt_x[3])) * ONE_L) / h);
        q1  = clip32(p + ONE_L);
        q2  = clip32(p + 2 * ONE_L);
        a   = clip32(fx_mul(p, d1));
        b   = clip32(fx_mul(p, q1));
        c   = clip32(fx_mul(b, q2));
        t2  = clip32(fx_mul(b, d2) / 2);
        t3  = clip32(fx_mul(c, d3) / 6);
        acc = clip32(y3 + a);
        acc = clip32(acc + t2);
        acc = clip32(acc + t3);
        r.value  = acc[31:0];
        r.status = sat_seen ? ST_SAT : ST_OK;
        return r;
    endfunction

    task automatic send_item(t_item it, logic typed, t_result typed_res);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0
                : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 160 : 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        start    <= 1'b1;
        cmd_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (it.func == FUNC_LOAD) begin
            if (pt_count < int'(NPTS)) begin
                pt_x[pt_count] = it.x_value;
                pt_y[pt_count] = it.y_value;
                pt_count++;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    pt_x[k] = pt_x[k + 1];
                    pt_y[k] = pt_y[k + 1];
                end
                pt_x[3] = it.x_value;
                pt_y[3] = it.y_value;
            end
        end else begin
            queued_answers.push_back(typed ? typed_res : newton_backward_eval(it.x_value));
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if (o_done) begin
                if (queued_answers.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got value %h status %0d",
                             $time, o_result.value, o_result.status);
                    mismatches++;
                end else begin
                    want = queued_answers.pop_front();
                    if (o_result.value !== want.value) begin
                        $display("%0t: value expected %h got %h",
                                 $time, want.value, o_result.value);
                        mismatches++;
                    end
                    if (o_result.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, o_result.status);
                        mismatches++;
                    end
                end
            end
            if ((start && !busy) || o_done) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("backward_difference_interpolator verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_item              it;
        t_result            no_res;
        logic signed [31:0] step, base;
        int                 yscale, nq, set_idx;
        no_res  = '0;
        set_idx = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < DIR_N; k++) begin
            send_item(DIRECTED[k].item, DIRECTED[k].typed, DIRECTED[k].res);
        end

        while (items_sent < DIR_N + RAND_ITEMS) begin
            set_idx++;
            if (set_idx == 4 || $urandom_range(0, 24) == 0) begin
                start <= 1'b0;
                @(negedge i_clk);
                wait (queued_answers.size() == 0);
                @(negedge i_clk);
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    it.func    = 1'($urandom_range(0, 1));
                    it.x_value = $urandom;
                    it.y_value = $urandom;
                    send_item(it, 1'b0, no_res);
                end
            end else begin
                step = $urandom_range(1, 32'h0004_0000);
                if ($urandom_range(0, 3) == 0) step = -step;
                if ($urandom_range(0, 11) == 0) step = 0;
                base   = $signed($urandom) >>> $urandom_range(6, 31);
                yscale = $urandom_range(0, 31);
                for (int k = 0; k < 4; k++) begin
                    it.func    = FUNC_LOAD;
                    it.x_value = base + k * step;
                    it.y_value = $signed($urandom) >>> yscale;
                    send_item(it, 1'b0, no_res);
                end
                nq = $urandom_range(1, 5);
                for (int k = 0; k < nq; k++) begin
                    it.func    = FUNC_QUERY;
                    it.x_value = ($urandom_range(0, 7) == 0) ? $urandom
                               : base + 3 * step + ($signed($urandom) >>> $urandom_range(9, 31));
                    it.y_value = $urandom;
                    send_item(it, 1'b0, no_res);
                end
            end
        end

        start <= 1'b0;
        wait (queued_answers.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("backward_difference_interpolator verification clean");
        end else begin
            $display("backward_difference_interpolator verification failed");
        end
        $finish;
    end

endmodule
